[src/mrqs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mrqs_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int WAIT_W = 16;
	localparam int DIV_W = $clog2(WAIT_W);

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DISPATCH = 3'd1;
	localparam logic [2:0] CMD_TICK = 3'd2;
	localparam logic [2:0] CMD_AGE = 3'd3;
	localparam logic [2:0] CMD_PREEMPT = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [2:0] CFG_THRESHOLD = 3'd0;
	localparam logic [2:0] CFG_STEP = 3'd1;
	localparam logic [2:0] CFG_CEILING = 3'd2;
	localparam logic [2:0] CFG_MID_FLOOR = 3'd3;
	localparam logic [2:0] CFG_TOP_FLOOR = 3'd4;

	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_TOP = 2'd1;
	localparam logic [1:0] LVL_MID = 2'd2;
	localparam logic [1:0] LVL_LOW = 2'd3;

	typedef struct packed {
		logic [7:0]        id;
		logic [7:0]        pri;
		logic [1:0]        lvl;
		logic [15:0]       rem;
		logic [WAIT_W-1:0] wtime;
	} entry_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_LOAD,
		DP_EXEC,
		DP_AGE_LOAD,
		DP_DIV,
		DP_MUL,
		DP_AGE_WR,
		DP_SORT
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [IDX_W-1:0] idx;
		logic             phase;
	} ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             age_hit;
	} sts_t;

	function automatic logic [1:0] level_of(input logic [7:0] p, input logic [7:0] mid,
			input logic [7:0] top);
		logic [1:0] l;
		if (p < mid) l = LVL_LOW;
		else if (p < top) l = LVL_MID;
		else l = LVL_TOP;
		return l;
	endfunction

	// strict ordering, ties keep arrival order
	function automatic logic goes_before(input entry_t a, input entry_t b);
		logic r;
		if (a.lvl != b.lvl) r = a.lvl < b.lvl;
		else if (a.lvl == LVL_TOP) r = a.rem < b.rem;
		else if (a.lvl == LVL_MID) r = a.pri < b.pri;
		else r = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

[src/multilevel_ready_queue_scheduler_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Multilevel ready-queue scheduler with aging, sixteen-entry sorted table.
// Command channel: a word is taken on a clock edge with start high and busy
// low; cmd selects insert, dispatch, add ticks, aging update or preempt check.
// Result channel: done pulses for one cycle with chosen_id, found, preempt,
// status and occupancy valid; the receiver cannot stall it and must take it.
// Config channel: cfg_ready is always high; cfg_index picks the register and
// cfg_data carries the value. Write only while no command is in flight.
// Insert, dispatch, tick, preempt check and unknown codes go through the
// execute state, which registers done with the result; a new command may
// be taken while done is high. Aging walks the table one entry at a time:
// a load, then for an entry above the threshold the shared restoring
// divider, a multiply and a write, for one at or below it only the write;
// then 16 odd-even sort passes before done.
// Reset clears the entry count and the running level and loads the default
// register values; table contents are only read below the entry count.
module multilevel_ready_queue_scheduler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  cmd,
	input  wire logic [7:0]  thread_id,
	input  wire logic [7:0]  priority_req,
	input  wire logic [15:0] remaining_time,
	input  wire logic [15:0] tick_count,
	input  wire logic        quantum_expired,
	output logic             done,
	output logic [7:0]       chosen_id,
	output logic             found,
	output logic             preempt,
	output logic [1:0]       status,
	output logic [4:0]       occupancy,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	mrqs_pkg::ctl_t ctl;
	mrqs_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	mrqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	mrqs_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cmd             (cmd),
		.thread_id       (thread_id),
		.priority_req    (priority_req),
		.remaining_time  (remaining_time),
		.tick_count      (tick_count),
		.quantum_expired (quantum_expired),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.chosen_id       (chosen_id),
		.found           (found),
		.preempt         (preempt),
		.status          (status),
		.occupancy       (occupancy)
	);

endmodule
`default_nettype wire

[src/mrqs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module mrqs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [2:0]     cmd,
	input  wire mrqs_pkg::sts_t sts,
	output mrqs_pkg::ctl_t      ctl,
	output logic                busy,
	output logic                done
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_EXEC    = 7'b0000010,
		S_AGE_LD  = 7'b0000100,
		S_AGE_DIV = 7'b0001000,
		S_AGE_MUL = 7'b0010000,
		S_AGE_WR  = 7'b0100000,
		S_SORT    = 7'b1000000
	} state_t;

	state_t                              state_q;
	logic [2:0]                          cmd_q;
	logic [mrqs_pkg::CNT_W-1:0]          idx_q;
	logic [mrqs_pkg::DIV_W-1:0]          div_q;
	logic [mrqs_pkg::IDX_W-1:0]          pass_q;
	logic                                done_q;

	always_comb begin
		ctl.op = mrqs_pkg::DP_NONE;
		ctl.idx = idx_q[mrqs_pkg::IDX_W-1:0];
		ctl.phase = pass_q[0];
		case (state_q)
			S_IDLE: if (start) ctl.op = mrqs_pkg::DP_LOAD;
			S_EXEC: ctl.op = mrqs_pkg::DP_EXEC;
			S_AGE_LD: ctl.op = mrqs_pkg::DP_AGE_LOAD;
			S_AGE_DIV: if (sts.age_hit) ctl.op = mrqs_pkg::DP_DIV;
			S_AGE_MUL: ctl.op = mrqs_pkg::DP_MUL;
			S_AGE_WR: ctl.op = mrqs_pkg::DP_AGE_WR;
			S_SORT: ctl.op = mrqs_pkg::DP_SORT;
			default: ctl.op = mrqs_pkg::DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= mrqs_pkg::CMD_INSERT;
			idx_q <= '0;
			div_q <= '0;
			pass_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q <= '0;
					pass_q <= '0;
					if (cmd_q == mrqs_pkg::CMD_AGE) begin
						if (sts.cnt == '0) state_q <= S_SORT;
						else state_q <= S_AGE_LD;
					end else begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_AGE_LD: begin
					div_q <= '0;
					state_q <= S_AGE_DIV;
				end
				S_AGE_DIV: begin
					// entries at or below the threshold skip the divider
					if (!sts.age_hit) begin
						state_q <= S_AGE_WR;
					end else begin
						div_q <= div_q + 1'b1;
						if (div_q == mrqs_pkg::DIV_W'(mrqs_pkg::WAIT_W - 1))
							state_q <= S_AGE_MUL;
					end
				end
				S_AGE_MUL: state_q <= S_AGE_WR;
				S_AGE_WR: begin
					idx_q <= idx_q + 1'b1;
					if (mrqs_pkg::CNT_W'(idx_q + 1'b1) == sts.cnt) state_q <= S_SORT;
					else state_q <= S_AGE_LD;
				end
				S_SORT: begin
					pass_q <= pass_q + 1'b1;
					if (pass_q == mrqs_pkg::IDX_W'(mrqs_pkg::TABLE_DEPTH - 1)) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

[src/mrqs_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module mrqs_dpath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mrqs_pkg::ctl_t ctl,
	output mrqs_pkg::sts_t      sts,
	input  wire logic [2:0]     cmd,
	input  wire logic [7:0]     thread_id,
	input  wire logic [7:0]     priority_req,
	input  wire logic [15:0]    remaining_time,
	input  wire logic [15:0]    tick_count,
	input  wire logic           quantum_expired,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [15:0]    cfg_data,
	output logic [7:0]          chosen_id,
	output logic                found,
	output logic                preempt,
	output logic [1:0]          status,
	output logic [4:0]          occupancy
);

	localparam int D = mrqs_pkg::TABLE_DEPTH;
	localparam int W = mrqs_pkg::WAIT_W;

	mrqs_pkg::entry_t tbl_q [D];
	mrqs_pkg::entry_t ins_next [D];
	mrqs_pkg::entry_t tick_next [D];
	mrqs_pkg::entry_t sort_next [D];
	mrqs_pkg::entry_t new_e;
	mrqs_pkg::entry_t aged;
	mrqs_pkg::entry_t cur_q;

	logic [2:0]                 cmd_q;
	logic [7:0]                 id_in_q;
	logic [7:0]                 pri_in_q;
	logic [15:0]                rem_in_q;
	logic [15:0]                tick_in_q;
	logic                       qexp_q;

	logic [15:0]                thresh_q;
	logic [7:0]                 step_q;
	logic [7:0]                 ceil_q;
	logic [7:0]                 mid_q;
	logic [7:0]                 top_q;
	logic [15:0]                th_eff;

	logic [mrqs_pkg::CNT_W-1:0] cnt_q;
	logic [1:0]                 run_lvl_q;
	logic [D-1:0]               ahead;
	logic                       full;
	logic                       empty;
	logic                       pre_c;

	logic                       age_hit_q;
	logic [W-1:0]               quo_q;
	logic [W-1:0]               rmd_q;
	logic [W:0]                 div_r;
	logic                       div_ge;
	logic [23:0]                prod_step_q;
	logic [W-1:0]               prod_th_q;
	logic [24:0]                psum;

	logic [7:0]                 chosen_q;
	logic                       found_q;
	logic                       preempt_q;
	logic [1:0]                 status_q;

	assign th_eff = (thresh_q == '0) ? 16'd1 : thresh_q;
	assign full = (cnt_q >= mrqs_pkg::CNT_W'(D));
	assign empty = (cnt_q == '0);

	always_comb begin
		new_e.id = id_in_q;
		new_e.pri = pri_in_q;
		new_e.lvl = mrqs_pkg::level_of(pri_in_q, mid_q, top_q);
		new_e.rem = rem_in_q;
		new_e.wtime = '0;
	end

	// table stays sorted, so the ahead flags form one run up to the end
	always_comb begin
		for (int i = 0; i < D; i++)
			ahead[i] = (mrqs_pkg::CNT_W'(i) < cnt_q) && mrqs_pkg::goes_before(new_e, tbl_q[i]);
		for (int i = 0; i < D; i++) begin
			if (i > 0 && ahead[i-1]) ins_next[i] = tbl_q[i-1];
			else if (ahead[i] || mrqs_pkg::CNT_W'(i) == cnt_q) ins_next[i] = new_e;
			else ins_next[i] = tbl_q[i];
		end
	end

	always_comb begin
		logic [W:0] s;
		for (int i = 0; i < D; i++) begin
			tick_next[i] = tbl_q[i];
			s = {1'b0, tbl_q[i].wtime} + {1'b0, tick_in_q};
			if (mrqs_pkg::CNT_W'(i) < cnt_q) tick_next[i].wtime = s[W] ? '1 : s[W-1:0];
		end
	end

	// odd-even transposition, swaps only on strict order so it stays stable
	always_comb begin
		for (int i = 0; i < D; i++) sort_next[i] = tbl_q[i];
		for (int j = 0; j < D - 1; j++) begin
			if (1'(j % 2) == ctl.phase && mrqs_pkg::CNT_W'(j + 1) < cnt_q
					&& mrqs_pkg::goes_before(tbl_q[j+1], tbl_q[j])) begin
				sort_next[j] = tbl_q[j+1];
				sort_next[j+1] = tbl_q[j];
			end
		end
	end

	always_comb begin
		pre_c = 1'b0;
		if (run_lvl_q == mrqs_pkg::LVL_TOP) pre_c = tbl_q[0].rem < rem_in_q;
		else if (run_lvl_q == mrqs_pkg::LVL_LOW) begin
			if (tbl_q[0].lvl == mrqs_pkg::LVL_TOP || tbl_q[0].lvl == mrqs_pkg::LVL_MID)
				pre_c = 1'b1;
			else pre_c = qexp_q;
		end
	end

	assign div_r = {rmd_q, quo_q[W-1]};
	assign div_ge = div_r >= {1'b0, th_eff};

	always_comb begin
		psum = 25'(cur_q.pri) + 25'(prod_step_q);
		aged = cur_q;
		if (age_hit_q) begin
			aged.pri = (psum > 25'(ceil_q)) ? ceil_q : psum[7:0];
			aged.wtime = cur_q.wtime - prod_th_q;
		end
		aged.lvl = mrqs_pkg::level_of(aged.pri, mid_q, top_q);
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			mrqs_pkg::DP_LOAD: begin
				cmd_q <= cmd;
				id_in_q <= thread_id;
				pri_in_q <= priority_req;
				rem_in_q <= remaining_time;
				tick_in_q <= tick_count;
				qexp_q <= quantum_expired;
			end
			mrqs_pkg::DP_EXEC: begin
				case (cmd_q)
					mrqs_pkg::CMD_INSERT: if (!full) tbl_q <= ins_next;
					mrqs_pkg::CMD_DISPATCH: begin
						if (!empty) for (int i = 0; i < D - 1; i++) tbl_q[i] <= tbl_q[i+1];
					end
					mrqs_pkg::CMD_TICK: tbl_q <= tick_next;
					default: ;
				endcase
			end
			mrqs_pkg::DP_AGE_LOAD: begin
				cur_q <= tbl_q[ctl.idx];
				age_hit_q <= tbl_q[ctl.idx].wtime > th_eff;
				quo_q <= tbl_q[ctl.idx].wtime - 1'b1;
				rmd_q <= '0;
			end
			mrqs_pkg::DP_DIV: begin
				rmd_q <= div_ge ? W'(div_r - {1'b0, th_eff}) : div_r[W-1:0];
				quo_q <= {quo_q[W-2:0], div_ge};
			end
			mrqs_pkg::DP_MUL: begin
				prod_step_q <= quo_q * step_q;
				prod_th_q <= W'(quo_q * th_eff);
			end
			mrqs_pkg::DP_AGE_WR: tbl_q[ctl.idx] <= aged;
			mrqs_pkg::DP_SORT: tbl_q <= sort_next;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_lvl_q <= mrqs_pkg::LVL_NONE;
			thresh_q <= 16'd1500;
			step_q <= 8'd10;
			ceil_q <= 8'd149;
			mid_q <= 8'd50;
			top_q <= 8'd100;
			chosen_q <= '0;
			found_q <= 1'b0;
			preempt_q <= 1'b0;
			status_q <= mrqs_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mrqs_pkg::CFG_THRESHOLD: thresh_q <= cfg_data;
					mrqs_pkg::CFG_STEP: step_q <= cfg_data[7:0];
					mrqs_pkg::CFG_CEILING: ceil_q <= cfg_data[7:0];
					mrqs_pkg::CFG_MID_FLOOR: mid_q <= cfg_data[7:0];
					mrqs_pkg::CFG_TOP_FLOOR: top_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (ctl.op == mrqs_pkg::DP_EXEC) begin
				chosen_q <= '0;
				found_q <= 1'b0;
				preempt_q <= 1'b0;
				status_q <= mrqs_pkg::ST_OK;
				case (cmd_q)
					mrqs_pkg::CMD_INSERT: begin
						if (full) status_q <= mrqs_pkg::ST_FULL;
						else cnt_q <= cnt_q + 1'b1;
					end
					mrqs_pkg::CMD_DISPATCH: begin
						if (empty) status_q <= mrqs_pkg::ST_EMPTY;
						else begin
							chosen_q <= tbl_q[0].id;
							found_q <= 1'b1;
							run_lvl_q <= tbl_q[0].lvl;
							cnt_q <= cnt_q - 1'b1;
						end
					end
					mrqs_pkg::CMD_PREEMPT: begin
						if (empty) status_q <= mrqs_pkg::ST_EMPTY;
						else preempt_q <= pre_c;
					end
					default: ;
				endcase
			end
		end
	end

	assign sts.cnt = cnt_q;
	assign sts.age_hit = age_hit_q;
	assign chosen_id = chosen_q;
	assign found = found_q;
	assign preempt = preempt_q;
	assign status = status_q;
	assign occupancy = 5'(cnt_q);

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  cmd = mrqs_pkg::CMD_INSERT;
	logic [7:0]  thread_id = '0;
	logic [7:0]  priority_req = '0;
	logic [15:0] remaining_time = '0;
	logic [15:0] tick_count = '0;
	logic        quantum_expired = 1'b0;
	logic        done;
	logic [7:0]  chosen_id;
	logic        found;
	logic        preempt;
	logic [1:0]  status;
	logic [4:0]  occupancy;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = mrqs_pkg::CFG_THRESHOLD;
	logic [15:0] cfg_data = '0;

	multilevel_ready_queue_scheduler_top uut (.*);

	always #4 clk = ~clk;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  id;
		logic [7:0]  pri;
		logic [15:0] rem;
		logic [15:0] ticks;
		logic        qexp;
	} word_t;

	typedef struct packed {
		logic [7:0] chosen;
		logic       found;
		logic       preempt;
		logic [1:0] status;
		logic [4:0] occ;
	} outcome_t;

	typedef struct packed {
		word_t    w;
		logic     typed;
		outcome_t res;
	} dir_row_t;

	typedef struct {
		logic [7:0]  id;
		logic [7:0]  pri;
		logic [1:0]  lvl;
		logic [15:0] rem;
		logic [15:0] wt;
	} thread_t;

	// scheduler shadow state
	thread_t    ready_q[mrqs_pkg::TABLE_DEPTH];
	int         n_ready;
	logic [1:0] run_lvl;
	int         age_thresh, age_step, pri_ceil, mid_floor, top_floor;

	outcome_t pending[$];
	int       errors = 0;

	function automatic logic [1:0] level_for(input int p);
		if (p < mid_floor) return mrqs_pkg::LVL_LOW;
		if (p < top_floor) return mrqs_pkg::LVL_MID;
		return mrqs_pkg::LVL_TOP;
	endfunction

	function automatic logic ahead_of(input thread_t a, input thread_t b);
		if (a.lvl != b.lvl) return a.lvl < b.lvl;
		if (a.lvl == mrqs_pkg::LVL_TOP) return a.rem < b.rem;
		if (a.lvl == mrqs_pkg::LVL_MID) return a.pri < b.pri;
		return 1'b0;
	endfunction

	task automatic schedule_word(input word_t w, output outcome_t r);
		thread_t t;
		int pos, th, k, p, wsum, j;
		r = '0;
		case (w.cmd)
		mrqs_pkg::CMD_INSERT: begin
			if (n_ready >= mrqs_pkg::TABLE_DEPTH) begin
				r.status = mrqs_pkg::ST_FULL;
			end else begin
				t.id = w.id;
				t.pri = w.pri;
				t.lvl = level_for(w.pri);
				t.rem = w.rem;
				t.wt = '0;
				pos = n_ready;
				for (int i = 0; i < n_ready; i++)
					if (pos == n_ready && ahead_of(t, ready_q[i])) pos = i;
				for (int i = n_ready; i > pos; i--) ready_q[i] = ready_q[i-1];
				ready_q[pos] = t;
				n_ready++;
			end
		end
		mrqs_pkg::CMD_DISPATCH: begin
			if (n_ready == 0) begin
				r.status = mrqs_pkg::ST_EMPTY;
			end else begin
				r.chosen = ready_q[0].id;
				r.found = 1'b1;
				run_lvl = ready_q[0].lvl;
				for (int i = 1; i < n_ready; i++) ready_q[i-1] = ready_q[i];
				n_ready--;
			end
		end
		mrqs_pkg::CMD_TICK: begin
			for (int i = 0; i < n_ready; i++) begin
				wsum = ready_q[i].wt + w.ticks;
				ready_q[i].wt = wsum > 65535 ? 16'hFFFF : wsum[15:0];
			end
		end
		mrqs_pkg::CMD_AGE: begin
			th = age_thresh == 0 ? 1 : age_thresh;
			for (int i = 0; i < n_ready; i++) begin
				if (ready_q[i].wt > th) begin
					k = (ready_q[i].wt - 1) / th;
					p = ready_q[i].pri + k * age_step;
					if (p > pri_ceil) p = pri_ceil;
					ready_q[i].pri = p[7:0];
					ready_q[i].wt = ready_q[i].wt - k * th;
				end
				ready_q[i].lvl = level_for(ready_q[i].pri);
			end
			// stable insertion sort
			for (int i = 1; i < n_ready; i++) begin
				t = ready_q[i];
				j = i;
				while (j > 0 && ahead_of(t, ready_q[j-1])) begin
					ready_q[j] = ready_q[j-1];
					j--;
				end
				ready_q[j] = t;
			end
		end
		mrqs_pkg::CMD_PREEMPT: begin
			if (n_ready == 0) r.status = mrqs_pkg::ST_EMPTY;
			else if (run_lvl == mrqs_pkg::LVL_TOP) r.preempt = ready_q[0].rem < w.rem;
			else if (run_lvl == mrqs_pkg::LVL_LOW)
				r.preempt = ready_q[0].lvl != mrqs_pkg::LVL_LOW || w.qexp;
		end
		default: ;
		endcase
		r.occ = n_ready[4:0];
	endtask

	task automatic send_word(input word_t w, input logic typed, input outcome_t want);
		int gap;
		outcome_t r;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		cmd = w.cmd;
		thread_id = w.id;
		priority_req = w.pri;
		remaining_time = w.rem;
		tick_count = w.ticks;
		quantum_expired = w.qexp;
		do @(posedge clk); while (busy);
		schedule_word(w, r);
		pending = {pending, (typed ? want : r)};
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val[15:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		mrqs_pkg::CFG_THRESHOLD: age_thresh = val & 16'hFFFF;
		mrqs_pkg::CFG_STEP:      age_step = val & 8'hFF;
		mrqs_pkg::CFG_CEILING:   pri_ceil = val & 8'hFF;
		mrqs_pkg::CFG_MID_FLOOR: mid_floor = val & 8'hFF;
		mrqs_pkg::CFG_TOP_FLOOR: top_floor = val & 8'hFF;
		default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word, actual %p", $time,
					{chosen_id, found, preempt, status, occupancy});
				errors++;
			end else begin
				e = pending.pop_front();
				if (chosen_id !== e.chosen) begin
					$display("%0t: chosen_id expected %0d actual %0d", $time, e.chosen, chosen_id);
					errors++;
				end
				if (found !== e.found) begin
					$display("%0t: found expected %0d actual %0d", $time, e.found, found);
					errors++;
				end
				if (preempt !== e.preempt) begin
					$display("%0t: preempt expected %0d actual %0d", $time, e.preempt, preempt);
					errors++;
				end
				if (status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, status);
					errors++;
				end
				if (occupancy !== e.occ) begin
					$display("%0t: occupancy expected %0d actual %0d", $time, e.occ, occupancy);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	// cmd, id, pri, rem, ticks, qexp, typed, {chosen, found, preempt, status, occ}
	dir_row_t dir_rows[] = '{
		'{'{mrqs_pkg::CMD_DISPATCH, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b1,
			'{8'd0, 1'b0, 1'b0, mrqs_pkg::ST_EMPTY, 5'd0}},
		'{'{mrqs_pkg::CMD_PREEMPT, 8'd0, 8'd0, 16'd9, 16'd0, 1'b1}, 1'b1,
			'{8'd0, 1'b0, 1'b0, mrqs_pkg::ST_EMPTY, 5'd0}},
		'{'{3'd5, 8'hFF, 8'd149, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
			'{8'd0, 1'b0, 1'b0, mrqs_pkg::ST_OK, 5'd0}},
		'{'{mrqs_pkg::CMD_INSERT, 8'hFF, 8'd149, 16'hFFFF, 16'd0, 1'b0}, 1'b1,
			'{8'd0, 1'b0, 1'b0, mrqs_pkg::ST_OK, 5'd1}},
		'{'{mrqs_pkg::CMD_INSERT, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b1,
			'{8'd0, 1'b0, 1'b0, mrqs_pkg::ST_OK, 5'd2}},
		'{'{mrqs_pkg::CMD_PREEMPT, 8'd0, 8'd0, 16'hFFFF, 16'd0, 1'b1}, 1'b1,
			'{8'd0, 1'b0, 1'b0, mrqs_pkg::ST_OK, 5'd2}},
		'{'{mrqs_pkg::CMD_INSERT, 8'd1, 8'd50, 16'd7, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_INSERT, 8'd2, 8'd99, 16'd3, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_INSERT, 8'd3, 8'd100, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_INSERT, 8'd4, 8'd49, 16'd5, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_INSERT, 8'd5, 8'd99, 16'd1, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_TICK, 8'd0, 8'd0, 16'd0, 16'hFFFF, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_TICK, 8'd0, 8'd0, 16'd0, 16'hFFFF, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_AGE, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_DISPATCH, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_PREEMPT, 8'd0, 8'd0, 16'hFFFF, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_PREEMPT, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
		'{'{3'd6, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
		'{'{3'd7, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_DISPATCH, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_DISPATCH, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_PREEMPT, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1}, 1'b0, '0},
		'{'{mrqs_pkg::CMD_PREEMPT, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0}
	};

	// threshold, step, ceiling, mid floor, top floor
	int settings[6][5] = '{
		'{1, 1, 0, 0, 0},
		'{65535, 149, 149, 149, 149},
		'{0, 149, 149, 30, 60},
		'{3, 7, 120, 50, 100},
		'{40, 25, 140, 120, 20},
		'{1500, 10, 149, 50, 100}
	};

	initial begin
		word_t w;
		int pick, fill_bias;
		n_ready = 0;
		run_lvl = mrqs_pkg::LVL_NONE;
		age_thresh = 1500;
		age_step = 10;
		pri_ceil = 149;
		mid_floor = 50;
		top_floor = 100;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
		// fill the table past its depth
		for (int i = 0; i < mrqs_pkg::TABLE_DEPTH + 2; i++)
			send_word('{mrqs_pkg::CMD_INSERT, 8'(i * 13), 8'(i * 9), 16'(i % 4), 16'd0, 1'b0},
				1'b0, '0);

		for (int ph = 0; ph < 6; ph++) begin
			start = 1'b0;
			while (pending.size() != 0) @(negedge clk);
			repeat (8) @(negedge clk);
			for (int r = 0; r < 5; r++) write_reg(3'(r), settings[ph][r]);
			fill_bias = $urandom_range(30, 70);
			for (int n = 0; n < 80; n++) begin
				w.id = 8'($urandom);
				w.pri = 8'($urandom_range(0, 149));
				w.rem = $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom);
				w.ticks = $urandom_range(0, 1) ? 16'($urandom_range(0, 200)) : 16'($urandom);
				w.qexp = 1'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < fill_bias) w.cmd = mrqs_pkg::CMD_INSERT;
				else if (pick < fill_bias + 12) w.cmd = mrqs_pkg::CMD_DISPATCH;
				else if (pick < fill_bias + 18) w.cmd = mrqs_pkg::CMD_TICK;
				else if (pick < fill_bias + 24) w.cmd = mrqs_pkg::CMD_AGE;
				else if (pick < 97) w.cmd = mrqs_pkg::CMD_PREEMPT;
				else w.cmd = 3'($urandom_range(5, 7));
				send_word(w, 1'b0, '0);
			end
		end

		start = 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (errors == 0 && pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
